>>> hw/rtl/ebc_pkg.sv
// ebc_pkg: shared types, byte codes and the CRC-8 (poly 0x9B) step function
// for the ebus CRC8 escape codec. No dependencies.
package ebc_pkg;

  typedef enum logic [1:0] {
    REQ_ENC_DATA  = 2'd0,
    REQ_ENC_FIN   = 2'd1,
    REQ_DEC_DATA  = 2'd2,
    REQ_DEC_CHECK = 2'd3
  } req_t;

  localparam logic [7:0] CRC_POLY = 8'h9B;
  localparam logic [7:0] ESC_BYTE = 8'hA9;
  localparam logic [7:0] SYN_BYTE = 8'hAA;
  localparam logic [7:0] ESC_SYN  = 8'h01;  // second byte of A9 01
  localparam logic [7:0] ESC_ESC  = 8'h00;  // second byte of A9 00

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       is_check;
    logic       crc_match;
    logic       run_last;
    logic       frame_done;
  } result_t;

  // Shift-in CRC: data bit enters at bit 0, MSB first; the bit leaving
  // bit 7 selects the XOR with the polynomial.
  function automatic logic [7:0] crc_update(input logic [7:0] crc,
                                            input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ? CRC_POLY : 8'h00;
      c  = {c[6:0], b[i]} ^ fb;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/ebus_crc8_escape_codec.sv
// ebus_crc8_escape_codec: byte stuffing encoder/decoder with CRC-8 (0x9B).
// Depends on ebc_pkg (request codes, result type, crc_update).
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_ready in_req_type            | into block
//          | in_data_byte                            |
//  out     | out_valid out_ready out_byte out_is_check | out of block
//          | out_crc_match out_run_last out_frame_done |
//
// An accepted beat is held in the input register, then its zero to
// two result beats are written into a four-entry result queue. The queue
// drains one beat per cycle while out_ready is high. Input ready depends
// only on registered state: the input register advances when the queue
// has room for two beats. rst_n clears the CRC, the escape flag, the input
// register and the queue pointers.
module ebus_crc8_escape_codec
  import ebc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_check,
  output logic       out_crc_match,
  output logic       out_run_last,
  output logic       out_frame_done
);

  // input register
  logic       s1_valid_r;
  req_t       s1_req_r;
  logic [7:0] s1_data_r;
  logic       s1_adv;

  // codec state
  logic [7:0] crc_r, crc_nxt;
  logic       esc_r, esc_nxt;

  // result queue
  result_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                pop;

  result_t    res0, res1;
  logic [1:0] n_res;
  logic [7:0] rx_byte;

  assign s1_adv   = s1_valid_r && (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_ready = !s1_valid_r || s1_adv;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_req_r   <= REQ_ENC_DATA;
      s1_data_r  <= 8'h00;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (in_valid && in_ready) begin
        s1_req_r  <= req_t'(in_req_type);
        s1_data_r <= in_data_byte;
      end
    end
  end

  // a byte after an escape resolves to AA for 01, else A9
  assign rx_byte = esc_r ? ((s1_data_r == ESC_SYN) ? SYN_BYTE : ESC_BYTE) : s1_data_r;

  always_comb begin
    res0    = '0;
    res1    = '0;
    n_res   = 2'd0;
    crc_nxt = crc_r;
    esc_nxt = esc_r;
    unique case (s1_req_r)
      REQ_ENC_DATA: begin
        if (s1_data_r == SYN_BYTE || s1_data_r == ESC_BYTE) begin
          res0.data     = ESC_BYTE;
          res1.data     = (s1_data_r == SYN_BYTE) ? ESC_SYN : ESC_ESC;
          res1.run_last = 1'b1;
          n_res         = 2'd2;
          crc_nxt       = crc_update(crc_update(crc_r, ESC_BYTE), res1.data);
        end else begin
          res0.data     = s1_data_r;
          res0.run_last = 1'b1;
          n_res         = 2'd1;
          crc_nxt       = crc_update(crc_r, s1_data_r);
        end
      end
      REQ_ENC_FIN: begin
        if (crc_r == SYN_BYTE || crc_r == ESC_BYTE) begin
          res0.data       = ESC_BYTE;
          res1.data       = (crc_r == SYN_BYTE) ? ESC_SYN : ESC_ESC;
          res1.run_last   = 1'b1;
          res1.frame_done = 1'b1;
          n_res           = 2'd2;
        end else begin
          res0.data       = crc_r;
          res0.run_last   = 1'b1;
          res0.frame_done = 1'b1;
          n_res           = 2'd1;
        end
        crc_nxt = 8'h00;
      end
      REQ_DEC_DATA: begin
        crc_nxt = crc_update(crc_r, s1_data_r);
        if (s1_data_r == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt       = 1'b0;
          res0.data     = rx_byte;
          res0.run_last = 1'b1;
          n_res         = 2'd1;
        end
      end
      REQ_DEC_CHECK: begin
        if (s1_data_r == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt         = 1'b0;
          res0.data       = rx_byte;
          res0.is_check   = 1'b1;
          res0.crc_match  = (rx_byte == crc_r);
          res0.run_last   = 1'b1;
          res0.frame_done = 1'b1;
          n_res           = 2'd1;
          crc_nxt         = 8'h00;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 8'h00;
      esc_r <= 1'b0;
    end else if (s1_adv) begin
      crc_r <= crc_nxt;
      esc_r <= esc_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + (s1_adv ? QCNT_W'(n_res) : QCNT_W'(0)) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (s1_adv && n_res != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (s1_adv && n_res == 2'd2) begin
      q_mem[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (s1_adv) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid      = (cnt_r != '0);
  assign out_byte       = q_mem[rd_ptr_r].data;
  assign out_is_check   = q_mem[rd_ptr_r].is_check;
  assign out_crc_match  = q_mem[rd_ptr_r].crc_match;
  assign out_run_last   = q_mem[rd_ptr_r].run_last;
  assign out_frame_done = q_mem[rd_ptr_r].frame_done;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[QPTR_W-1:0] == QPTR_W'(wr_ptr_r - rd_ptr_r))
    else $error("queue count disagrees with pointers");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_req_r == REQ_ENC_FIN) |=> crc_r == 8'h00)
    else $error("finish did not clear crc");

  a_enc_keeps_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_req_r == REQ_ENC_DATA || s1_req_r == REQ_ENC_FIN))
      |=> esc_r == $past(esc_r))
    else $error("encode changed escape flag");
`endif

endmodule
